[src/lssd_pkg.sv]
`timescale 1ns / 1ps

package lssd_pkg;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_PTR,
      RD_DN,
      RD_UP,
      RD_UP2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_PUSH,
      WR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      OCC_HOLD,
      OCC_INC,
      OCC_DEC
   } occ_op_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_DEC,
      PTR_INC
   } ptr_op_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_FULL,
      RES_EMPTY,
      RES_NOTFOUND,
      RES_PUSHED,
      RES_POP,
      RES_FOUND,
      RES_DELETED
   } res_kind_type;

   typedef struct packed {
      logic         capture;
      logic         rd_en;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      occ_op_type   occ_op;
      ptr_op_type   ptr_op;
      res_kind_type res_kind;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      op_type opcode;
      logic   full;
      logic   empty;
      logic   match;
      logic   ptr_bottom;
      logic   ptr_top;
      logic   shift_last;
      logic   out_free;
   } stat_type;

endpackage

[src/lssd_ctrl.sv]
`timescale 1ns / 1ps

module lssd_ctrl import lssd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.rd_sel   = RD_PTR;
      cmd.wr_sel   = WR_NONE;
      cmd.occ_op   = OCC_HOLD;
      cmd.ptr_op   = PTR_HOLD;
      cmd.res_kind = RES_NONE;
      cmd.emit     = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.opcode)
               OP_PUSH: begin
                  if (stat.full) begin
                     cmd.res_kind = RES_FULL;
                  end else begin
                     cmd.wr_sel   = WR_PUSH;
                     cmd.occ_op   = OCC_INC;
                     cmd.res_kind = RES_PUSHED;
                  end
                  state_in = ST_DONE;
               end
               OP_POP: begin
                  if (stat.empty) begin
                     cmd.res_kind = RES_EMPTY;
                     state_in     = ST_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.occ_op = OCC_DEC;
                     state_in   = ST_POP;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     cmd.res_kind = RES_EMPTY;
                     state_in     = ST_DONE;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_SCAN;
                  end
               end
            endcase
         end
         ST_POP: begin
            cmd.res_kind = RES_POP;
            state_in     = ST_DONE;
         end
         ST_SCAN: begin
            if (stat.match) begin
               if (stat.opcode == OP_SEARCH) begin
                  cmd.res_kind = RES_FOUND;
                  state_in     = ST_DONE;
               end else if (stat.ptr_top) begin
                  cmd.occ_op   = OCC_DEC;
                  cmd.res_kind = RES_DELETED;
                  state_in     = ST_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_UP;
                  state_in   = ST_SHIFT;
               end
            end else if (stat.ptr_bottom) begin
               cmd.res_kind = RES_NOTFOUND;
               state_in     = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_DN;
               cmd.ptr_op = PTR_DEC;
            end
         end
         ST_SHIFT: begin
            cmd.wr_sel = WR_SHIFT;
            cmd.ptr_op = PTR_INC;
            if (stat.shift_last) begin
               cmd.occ_op   = OCC_DEC;
               cmd.res_kind = RES_DELETED;
               state_in     = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_UP2;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/lssd_datapath.sv]
`timescale 1ns / 1ps

module lssd_datapath import lssd_pkg::*; #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic        [1:0]  req_opcode,
   input  logic signed [31:0] req_operand,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_data,
   output logic        [7:0]  rsp_pos_from_bottom,
   output logic        [7:0]  rsp_pos_from_top
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam int PW = (OW > 8) ? OW : 8;

   logic [DATA_WIDTH-1:0] entries_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   op_type                opcode_ff;
   logic [OW-1:0]         occ_ff, occ_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         rd_addr;

   status_type            res_status_ff, res_status_in;
   logic [31:0]           res_data_ff, res_data_in;
   logic [7:0]            res_pb_ff, res_pb_in;
   logic [7:0]            res_pt_ff, res_pt_in;
   logic [PW-1:0]         pb_full, pt_full;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [31:0]           rsp_data_ff;
   logic [7:0]            rsp_pb_ff, rsp_pt_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_PTR:  rd_addr = ptr_ff;
         RD_DN:   rd_addr = ptr_ff - AW'(1);
         RD_UP:   rd_addr = ptr_ff + AW'(1);
         RD_UP2:  rd_addr = ptr_ff + AW'(2);
         default: rd_addr = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
      case (cmd.wr_sel)
         WR_PUSH:  entries_ff[occ_ff[AW-1:0]] <= val_ff;
         WR_SHIFT: entries_ff[ptr_ff] <= rd_data_ff;
         default:  ;
      endcase
   end

   always_comb begin
      case (cmd.occ_op)
         OCC_INC: occ_in = occ_ff + OW'(1);
         OCC_DEC: occ_in = occ_ff - OW'(1);
         default: occ_in = occ_ff;
      endcase
      if (cmd.capture) begin
         ptr_in = AW'(occ_ff - OW'(1));
      end else begin
         case (cmd.ptr_op)
            PTR_DEC: ptr_in = ptr_ff - AW'(1);
            PTR_INC: ptr_in = ptr_ff + AW'(1);
            default: ptr_in = ptr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
      ptr_ff <= ptr_in;
      if (cmd.capture) begin
         opcode_ff <= op_type'(req_opcode);
         val_ff    <= DATA_WIDTH'($unsigned(req_operand));
      end
   end

   assign pb_full = PW'(ptr_ff) + PW'(1);
   assign pt_full = PW'(occ_ff) - PW'(ptr_ff);

   always_comb begin
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_pb_in     = res_pb_ff;
      res_pt_in     = res_pt_ff;
      if (cmd.res_kind != RES_NONE) begin
         res_status_in = STAT_OK;
         res_data_in   = '0;
         res_pb_in     = '0;
         res_pt_in     = '0;
      end
      case (cmd.res_kind)
         RES_FULL:     res_status_in = STAT_FULL;
         RES_EMPTY:    res_status_in = STAT_EMPTY;
         RES_NOTFOUND: res_status_in = STAT_NOTFOUND;
         RES_POP:      res_data_in   = 32'(rd_data_ff);
         RES_FOUND: begin
            res_data_in = 32'(val_ff);
            res_pb_in   = pb_full[7:0];
            res_pt_in   = pt_full[7:0];
         end
         RES_DELETED:  res_data_in   = 32'(val_ff);
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_pb_ff     <= res_pb_in;
      res_pt_ff     <= res_pt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_pb_ff     <= res_pb_ff;
         rsp_pt_ff     <= res_pt_ff;
      end
   end

   assign stat.opcode     = opcode_ff;
   assign stat.full       = (occ_ff == OW'(DEPTH));
   assign stat.empty      = (occ_ff == '0);
   assign stat.match      = (rd_data_ff == val_ff);
   assign stat.ptr_bottom = (ptr_ff == '0);
   assign stat.ptr_top    = ((OW'(ptr_ff) + OW'(1)) == occ_ff);
   assign stat.shift_last = ((OW'(ptr_ff) + OW'(2)) == occ_ff);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_data            = $signed(rsp_data_ff);
   assign rsp_pos_from_bottom = rsp_pb_ff;
   assign rsp_pos_from_top    = rsp_pt_ff;

endmodule

[src/lifo_stack_search_delete_top.sv]
`timescale 1ns / 1ps
// Channel  Ports                                         Direction
// req      req_valid req_stall req_opcode req_operand    in
// rsp      rsp_valid rsp_stall rsp_status rsp_data
//          rsp_pos_from_bottom rsp_pos_from_top          out
//
// Push and ops on an empty stack go from accept through EXEC to DONE; pop also passes through POP.
// Search and delete scan down from the top one entry a cycle through the
// stack memory's single registered read port; delete then shifts the entries
// above, one per cycle.
// Reset clears the occupancy, the controller state and rsp_valid; entry contents are not cleared.
// A word is accepted while an earlier result still waits behind rsp_stall.

module lifo_stack_search_delete_top import lssd_pkg::*; #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [1:0]  req_opcode,
   input  logic signed [31:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_data,
   output logic        [7:0]  rsp_pos_from_bottom,
   output logic        [7:0]  rsp_pos_from_top
);

   cmd_type  cmd;
   stat_type stat;

   lssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lssd_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_opcode          (req_opcode),
      .req_operand         (req_operand),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_data            (rsp_data),
      .rsp_pos_from_bottom (rsp_pos_from_bottom),
      .rsp_pos_from_top    (rsp_pos_from_top)
   );

endmodule

[tb/lifo_result_checker.sv]
`timescale 1ns / 1ps

module lifo_result_checker import lssd_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic        [1:0]  req_opcode,
   input  logic signed [31:0] req_operand,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic        [1:0]  rsp_status,
   input  logic signed [31:0] rsp_data,
   input  logic        [7:0]  rsp_pos_from_bottom,
   input  logic        [7:0]  rsp_pos_from_top,
   output int                 mismatch_count,
   output int                 results_owed
);

   typedef struct {
      status_type  status;
      logic [31:0] data;
      logic [7:0]  from_bottom;
      logic [7:0]  from_top;
   } stack_result_type;

   logic [31:0]      stack_words [DEPTH];
   int               stack_fill;
   stack_result_type pending_results [$];
   stack_result_type want;

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      stack_fill     = 0;
   end

   task automatic report_mismatch(string field, logic [31:0] wanted, logic [31:0] seen);
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, wanted, seen);
      mismatch_count++;
   endtask

   function automatic int topmost_match(logic [31:0] value);
      for (int k = stack_fill - 1; k >= 0; k--) begin
         if (stack_words[k] == value) return k;
      end
      return -1;
   endfunction

   task automatic apply_stack_op(op_type op, logic [31:0] value);
      stack_result_type r;
      int               hit;
      r   = '{STAT_OK, 32'd0, 8'd0, 8'd0};
      hit = -1;
      case (op)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               stack_words[stack_fill] = value;
               stack_fill++;
            end
         end
         OP_POP: begin
            if (stack_fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               stack_fill--;
               r.data = stack_words[stack_fill];
            end
         end
         default: begin
            if (stack_fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               hit = topmost_match(value);
               if (hit < 0) begin
                  r.status = STAT_NOTFOUND;
               end else begin
                  r.data = value;
                  if (op == OP_SEARCH) begin
                     r.from_bottom = 8'(hit + 1);
                     r.from_top    = 8'(stack_fill - hit);
                  end else begin
                     // close the gap: everything above the hit moves down
                     for (int k = hit; k + 1 < stack_fill; k++) begin
                        stack_words[k] = stack_words[k + 1];
                     end
                     stack_fill--;
                  end
               end
            end
         end
      endcase
      pending_results.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stack_fill = 0;
         pending_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            apply_stack_op(op_type'(req_opcode), req_operand);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unrequested word", 32'd0, rsp_data);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_data !== want.data)
                  report_mismatch("data", want.data, rsp_data);
               if (rsp_pos_from_bottom !== want.from_bottom)
                  report_mismatch("pos_from_bottom", 32'(want.from_bottom),
                                  32'(rsp_pos_from_bottom));
               if (rsp_pos_from_top !== want.from_top)
                  report_mismatch("pos_from_top", 32'(want.from_top), 32'(rsp_pos_from_top));
            end
         end
      end
      results_owed <= pending_results.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top import lssd_pkg::*;;

   localparam int DEPTH       = 128;
   localparam int QUIET_LIMIT = 3000;
   localparam int TAIL_CYCLES = 300;
   localparam int RANDOM_OPS  = 600;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} traffic_mode_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic        [1:0]  req_opcode  = OP_PUSH;
   logic signed [31:0] req_operand = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic        [1:0]  rsp_status;
   logic signed [31:0] rsp_data;
   logic        [7:0]  rsp_pos_from_bottom;
   logic        [7:0]  rsp_pos_from_top;

   int               mismatch_count;
   int               results_owed;
   int               quiet_cycles = 0;
   int               rsp_hold     = 0;
   logic             idle_on      = 1'b1;
   traffic_mode_type mode;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   lifo_stack_search_delete_top #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_operand(req_operand),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_data(rsp_data),
      .rsp_pos_from_bottom(rsp_pos_from_bottom),
      .rsp_pos_from_top(rsp_pos_from_top)
   );

   lifo_result_checker #(
      .DEPTH(DEPTH)
   ) result_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_operand(req_operand),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_data(rsp_data),
      .rsp_pos_from_bottom(rsp_pos_from_bottom),
      .rsp_pos_from_top(rsp_pos_from_top),
      .mismatch_count(mismatch_count),
      .results_owed(results_owed)
   );

   task automatic send_word(op_type op, logic [31:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_operand <= value;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic op_type pick_op(traffic_mode_type m);
      int r;
      r = $urandom_range(0, 99);
      case (m)
         PH_FILL: begin
            if (r < 85) return OP_PUSH;
            if (r < 90) return OP_POP;
            if (r < 97) return OP_SEARCH;
            return OP_DELETE;
         end
         PH_DRAIN: begin
            if (r < 8) return OP_PUSH;
            if (r < 68) return OP_POP;
            if (r < 80) return OP_SEARCH;
            return OP_DELETE;
         end
         default: return op_type'($urandom_range(0, 3));
      endcase
   endfunction

   // bias toward a few values so search and delete hit often
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3, 4, 5: return 32'($urandom_range(0, 7));
         default: return $urandom();
      endcase
   endfunction

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         rsp_hold = idle_on ? $urandom_range(0, 9) : 0;
         rsp_stall <= (rsp_hold != 0);
      end else if (rsp_hold > 1) begin
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_POP, 32'd0);
      send_word(OP_SEARCH, 32'd5);
      send_word(OP_DELETE, 32'd5);
      send_word(OP_PUSH, 32'h8000_0000);
      send_word(OP_PUSH, 32'h7fff_ffff);
      send_word(OP_PUSH, 32'd0);
      send_word(OP_PUSH, 32'hffff_ffff);
      send_word(OP_PUSH, 32'h7fff_ffff);
      send_word(OP_SEARCH, 32'h7fff_ffff);
      send_word(OP_SEARCH, 32'h8000_0000);
      send_word(OP_SEARCH, 32'h0001_2345);
      send_word(OP_DELETE, 32'h0001_2345);
      send_word(OP_DELETE, 32'h7fff_ffff);
      send_word(OP_SEARCH, 32'h7fff_ffff);
      send_word(OP_DELETE, 32'd0);
      send_word(OP_SEARCH, 32'hffff_ffff);
      send_word(OP_DELETE, 32'h8000_0000);
      send_word(OP_POP, 32'hffff_ffff);
      send_word(OP_POP, 32'd0);
      send_word(OP_POP, 32'd0);
      send_word(OP_PUSH, 32'd5);
      send_word(OP_DELETE, 32'd5);
      send_word(OP_SEARCH, 32'd5);

      // fill past full, drain past empty, then mix freely
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) idle_on <= ($urandom_range(0, 3) != 0);
         if (n < 180) mode = PH_FILL;
         else if (n < 380) mode = PH_DRAIN;
         else mode = PH_MIXED;
         send_word(pick_op(mode), pick_value());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
